[rtl/assert_macros.svh]
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is active
`define CHK_HOLDS(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication, off while reset is active
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

[rtl/cau_pkg.sv]
// types, constants and saturation helpers of the complex arithmetic unit
package cau_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int INT_WIDTH  = 16;
    localparam int PW = 2 * DATA_WIDTH;
    localparam int SW = PW + 1;
    localparam int NW = PW + FRAC_BITS;
    localparam int AW = ((DATA_WIDTH > INT_WIDTH + FRAC_BITS) ?
                         DATA_WIDTH : INT_WIDTH + FRAC_BITS) + 1;
    localparam int MW = ((PW > AW) ? PW : AW) + 1;

    typedef enum logic [2:0] {
        FN_ADD  = 3'd0,
        FN_ADDI = 3'd1,
        FN_MUL  = 3'd2,
        FN_DIV  = 3'd3,
        FN_CONJ = 3'd4,
        FN_MOD  = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_SAT  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        K_SIMPLE = 2'd0,
        K_DIV    = 2'd1,
        K_MOD    = 2'd2
    } kind_t;

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    typedef struct packed {
        logic [2:0]                   func;
        data_t                        a_re;
        data_t                        a_im;
        data_t                        b_re;
        data_t                        b_im;
        logic signed [INT_WIDTH-1:0]  int_addend;
    } in_word_t;

    typedef struct packed {
        data_t   res_re;
        data_t   res_im;
        status_t status;
    } out_word_t;

    typedef struct packed {
        logic  ovf;
        data_t val;
    } sat_t;

    // what travels beside the iterative datapath
    typedef struct packed {
        kind_t   kind;
        data_t   s_re;
        data_t   s_im;
        status_t s_st;
        logic    neg_re;
        logic    neg_im;
    } side_t;

    typedef struct packed {
        side_t           side;
        logic [PW-1:0]   den;
        logic [PW-1:0]   num_re;
        logic [PW-1:0]   num_im;
    } front_t;

    typedef struct packed {
        side_t                  side;
        logic [DATA_WIDTH-1:0]  q_re;
        logic [DATA_WIDTH-1:0]  q_im;
        logic                   ovf_re;
        logic                   ovf_im;
        logic [DATA_WIDTH-1:0]  root;
    } iter_out_t;

    // clamp a sign and magnitude to the signed data range
    function automatic sat_t sat_put(logic neg, logic [MW-1:0] mag);
        logic [MW-1:0] lim;
        sat_t          r;
        lim   = (MW'(1) << (DATA_WIDTH - 1)) - MW'(!neg);
        r.ovf = mag > lim;
        r.val = r.ovf ? lim[DATA_WIDTH-1:0] : mag[DATA_WIDTH-1:0];
        if (neg)
        begin
            r.val = -r.val;
        end
        return r;
    endfunction

    function automatic sat_t sat_val(logic signed [AW-1:0] v);
        logic [AW:0] ext;
        logic [AW:0] m;
        ext = {v[AW-1], v};
        m   = v[AW-1] ? -ext : ext;
        return sat_put(v[AW-1], MW'(m));
    endfunction

endpackage

[rtl/cau_front.sv]
// front stages: products, sums, magnitudes and the simple operations
module cau_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_ready,
    input  cau_pkg::in_word_t up_data,
    output logic             dn_valid,
    input  logic             dn_ready,
    output cau_pkg::front_t  dn_data
);
    import cau_pkg::*;

    typedef struct packed {
        logic [2:0]           func;
        logic signed [PW-1:0] p_rr;
        logic signed [PW-1:0] p_ii;
        logic signed [PW-1:0] p_ri;
        logic signed [PW-1:0] p_ir;
        logic signed [PW-1:0] sq_r;
        logic signed [PW-1:0] sq_i;
        data_t                s_re;
        data_t                s_im;
        status_t              s_st;
    } prod_t;

    typedef struct packed {
        logic [2:0]           func;
        logic signed [SW-1:0] sum_re;
        logic signed [SW-1:0] sum_im;
        logic [PW-1:0]        den;
        data_t                s_re;
        data_t                s_im;
        status_t              s_st;
    } sum_t;

    prod_t  prod_next, prod_reg;
    sum_t   sum_next, sum_reg;
    front_t mag_next, mag_reg;
    logic   a_valid_reg, b_valid_reg, c_valid_reg;
    logic   en_a, en_b, en_c;

    assign en_c     = !c_valid_reg || dn_ready;
    assign en_b     = !b_valid_reg || en_c;
    assign en_a     = !a_valid_reg || en_b;
    assign up_ready = en_a;
    assign dn_valid = c_valid_reg;
    assign dn_data  = mag_reg;

    // products and the operations that need no multiplier
    always_comb
    begin
        sat_t  re_sat;
        sat_t  im_sat;
        data_t x_re;
        data_t x_im;
        x_re = (up_data.func == FN_MOD) ? up_data.a_re : up_data.b_re;
        x_im = (up_data.func == FN_MOD) ? up_data.a_im : up_data.b_im;
        prod_next.func = up_data.func;
        prod_next.p_rr = PW'(up_data.a_re) * PW'(up_data.b_re);
        prod_next.p_ii = PW'(up_data.a_im) * PW'(up_data.b_im);
        prod_next.p_ri = PW'(up_data.a_re) * PW'(up_data.b_im);
        prod_next.p_ir = PW'(up_data.a_im) * PW'(up_data.b_re);
        prod_next.sq_r = PW'(x_re) * PW'(x_re);
        prod_next.sq_i = PW'(x_im) * PW'(x_im);
        re_sat = '0;
        im_sat = '0;
        case (up_data.func)
            FN_ADD:
            begin
                re_sat = sat_val(AW'(up_data.a_re) + AW'(up_data.b_re));
                im_sat = sat_val(AW'(up_data.a_im) + AW'(up_data.b_im));
            end
            FN_ADDI:
            begin
                re_sat = sat_val(AW'(up_data.a_re) + (AW'(up_data.int_addend) <<< FRAC_BITS));
                im_sat = '{ovf: 1'b0, val: up_data.a_im};
            end
            FN_CONJ:
            begin
                re_sat = '{ovf: 1'b0, val: up_data.a_re};
                im_sat = sat_val(-AW'(up_data.a_im));
            end
            default:
            begin
            end
        endcase
        prod_next.s_re = re_sat.val;
        prod_next.s_im = im_sat.val;
        prod_next.s_st = (re_sat.ovf || im_sat.ovf) ? ST_SAT : ST_OK;
    end

    // cross sums for multiply and divide, squared norm
    always_comb
    begin
        sum_next.func   = prod_reg.func;
        sum_next.s_re   = prod_reg.s_re;
        sum_next.s_im   = prod_reg.s_im;
        sum_next.s_st   = prod_reg.s_st;
        sum_next.den    = PW'($unsigned(prod_reg.sq_r)) + PW'($unsigned(prod_reg.sq_i));
        sum_next.sum_re = '0;
        sum_next.sum_im = '0;
        case (prod_reg.func)
            FN_MUL:
            begin
                sum_next.sum_re = SW'(prod_reg.p_rr) - SW'(prod_reg.p_ii);
                sum_next.sum_im = SW'(prod_reg.p_ri) + SW'(prod_reg.p_ir);
            end
            FN_DIV:
            begin
                sum_next.sum_re = SW'(prod_reg.p_rr) + SW'(prod_reg.p_ii);
                sum_next.sum_im = SW'(prod_reg.p_ir) - SW'(prod_reg.p_ri);
            end
            default:
            begin
            end
        endcase
    end

    // magnitudes, multiply result and divide-by-zero
    always_comb
    begin
        logic [SW-1:0] abs_re;
        logic [SW-1:0] abs_im;
        sat_t          re_sat;
        sat_t          im_sat;
        abs_re = sum_reg.sum_re[SW-1] ? -sum_reg.sum_re : sum_reg.sum_re;
        abs_im = sum_reg.sum_im[SW-1] ? -sum_reg.sum_im : sum_reg.sum_im;
        re_sat = sat_put(sum_reg.sum_re[SW-1], MW'(abs_re[PW-1:0] >> FRAC_BITS));
        im_sat = sat_put(sum_reg.sum_im[SW-1], MW'(abs_im[PW-1:0] >> FRAC_BITS));
        mag_next.den         = sum_reg.den;
        mag_next.num_re      = abs_re[PW-1:0];
        mag_next.num_im      = abs_im[PW-1:0];
        mag_next.side.kind   = K_SIMPLE;
        mag_next.side.s_re   = sum_reg.s_re;
        mag_next.side.s_im   = sum_reg.s_im;
        mag_next.side.s_st   = sum_reg.s_st;
        mag_next.side.neg_re = sum_reg.sum_re[SW-1];
        mag_next.side.neg_im = sum_reg.sum_im[SW-1];
        case (sum_reg.func)
            FN_MUL:
            begin
                mag_next.side.s_re = re_sat.val;
                mag_next.side.s_im = im_sat.val;
                mag_next.side.s_st = (re_sat.ovf || im_sat.ovf) ? ST_SAT : ST_OK;
            end
            FN_DIV:
            begin
                if (sum_reg.den == '0)
                begin
                    mag_next.side.s_re = '0;
                    mag_next.side.s_im = '0;
                    mag_next.side.s_st = ST_DIV0;
                end
                else
                begin
                    mag_next.side.kind = K_DIV;
                end
            end
            FN_MOD:
            begin
                mag_next.side.kind = K_MOD;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                a_valid_reg <= up_valid;
            end
            if (en_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (en_c)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            prod_reg <= prod_next;
        end
        if (en_b)
        begin
            sum_reg <= sum_next;
        end
        if (en_c)
        begin
            mag_reg <= mag_next;
        end
    end

endmodule

[rtl/cau_iter.sv]
// one quotient bit per stage for both divides, one root bit for the modulus
module cau_iter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  cau_pkg::front_t    up_data,
    output logic               dn_valid,
    input  logic               dn_ready,
    output cau_pkg::iter_out_t dn_data
);
    import cau_pkg::*;

    localparam int RW = DATA_WIDTH + 2;
    localparam int TW = DATA_WIDTH + 4;

    typedef struct packed {
        side_t                  side;
        logic [PW-1:0]          den;
        logic [PW-1:0]          r_re;
        logic [PW-1:0]          r_im;
        logic [DATA_WIDTH-1:0]  lo_re;
        logic [DATA_WIDTH-1:0]  lo_im;
        logic [DATA_WIDTH-1:0]  q_re;
        logic [DATA_WIDTH-1:0]  q_im;
        logic                   ovf_re;
        logic                   ovf_im;
        logic [PW-1:0]          sq_n;
        logic [RW-1:0]          sq_rem;
        logic [DATA_WIDTH-1:0]  sq_root;
    } step_t;

    // numerator scaled by the fraction; its upper part seeds the remainder
    function automatic step_t load_step(front_t f);
        logic [NW-1:0] n_re;
        logic [NW-1:0] n_im;
        step_t         s;
        n_re      = {f.num_re, {FRAC_BITS{1'b0}}};
        n_im      = {f.num_im, {FRAC_BITS{1'b0}}};
        s.side    = f.side;
        s.den     = f.den;
        s.r_re    = PW'(n_re[NW-1:DATA_WIDTH]);
        s.r_im    = PW'(n_im[NW-1:DATA_WIDTH]);
        s.lo_re   = n_re[DATA_WIDTH-1:0];
        s.lo_im   = n_im[DATA_WIDTH-1:0];
        s.q_re    = '0;
        s.q_im    = '0;
        s.ovf_re  = NW'(n_re[NW-1:DATA_WIDTH]) >= NW'(f.den);
        s.ovf_im  = NW'(n_im[NW-1:DATA_WIDTH]) >= NW'(f.den);
        s.sq_n    = f.den;
        s.sq_rem  = '0;
        s.sq_root = '0;
        return s;
    endfunction

    function automatic step_t work_step(step_t s);
        logic [PW:0] d;
        logic [PW:0] t_re;
        logic [PW:0] t_im;
        logic        ge_re;
        logic        ge_im;
        logic [TW-1:0] t_sq;
        logic [TW-1:0] trial;
        logic        ge_sq;
        step_t       o;
        o     = s;
        d     = {1'b0, s.den};
        t_re  = {s.r_re, s.lo_re[DATA_WIDTH-1]};
        t_im  = {s.r_im, s.lo_im[DATA_WIDTH-1]};
        ge_re = t_re >= d;
        ge_im = t_im >= d;
        o.r_re  = ge_re ? PW'(t_re - d) : t_re[PW-1:0];
        o.r_im  = ge_im ? PW'(t_im - d) : t_im[PW-1:0];
        o.lo_re = s.lo_re << 1;
        o.lo_im = s.lo_im << 1;
        o.q_re  = {s.q_re[DATA_WIDTH-2:0], ge_re};
        o.q_im  = {s.q_im[DATA_WIDTH-2:0], ge_im};
        // digit-by-digit square root, two radicand bits per stage
        t_sq  = {s.sq_rem, s.sq_n[PW-1 -: 2]};
        trial = {2'b00, s.sq_root, 2'b01};
        ge_sq = t_sq >= trial;
        o.sq_rem  = ge_sq ? RW'(t_sq - trial) : t_sq[RW-1:0];
        o.sq_root = {s.sq_root[DATA_WIDTH-2:0], ge_sq};
        o.sq_n    = s.sq_n << 2;
        return o;
    endfunction

    step_t                 st_reg [DATA_WIDTH];
    logic [DATA_WIDTH-1:0] valid_reg;
    logic [DATA_WIDTH:0]   rdy;

    assign rdy[DATA_WIDTH] = dn_ready;
    assign up_ready        = rdy[0];
    assign dn_valid        = valid_reg[DATA_WIDTH-1];

    for (genvar k = 0; k < DATA_WIDTH; k++)
    begin : g_stage
        step_t st_in;
        logic  v_in;

        if (k == 0)
        begin : g_first
            assign st_in = load_step(up_data);
            assign v_in  = up_valid;
        end
        else
        begin : g_rest
            assign st_in = st_reg[k-1];
            assign v_in  = valid_reg[k-1];
        end

        assign rdy[k] = !valid_reg[k] || rdy[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                st_reg[k] <= work_step(st_in);
            end
        end
    end

    assign dn_data.side   = st_reg[DATA_WIDTH-1].side;
    assign dn_data.q_re   = st_reg[DATA_WIDTH-1].q_re;
    assign dn_data.q_im   = st_reg[DATA_WIDTH-1].q_im;
    assign dn_data.ovf_re = st_reg[DATA_WIDTH-1].ovf_re;
    assign dn_data.ovf_im = st_reg[DATA_WIDTH-1].ovf_im;
    assign dn_data.root   = st_reg[DATA_WIDTH-1].sq_root;

endmodule

[rtl/cau_back.sv]
// result select, sign and saturation, output register
module cau_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  cau_pkg::iter_out_t up_data,
    output logic               dn_valid,
    input  logic               dn_stall,
    output cau_pkg::out_word_t dn_data
);
    import cau_pkg::*;

    out_word_t out_next, out_reg;
    logic      out_valid_reg;

    assign up_ready = !out_valid_reg || !dn_stall;
    assign dn_valid = out_valid_reg;
    assign dn_data  = out_reg;

    always_comb
    begin
        sat_t re_sat;
        sat_t im_sat;
        re_sat = '0;
        im_sat = '0;
        out_next.res_re = up_data.side.s_re;
        out_next.res_im = up_data.side.s_im;
        out_next.status = up_data.side.s_st;
        case (up_data.side.kind)
            K_SIMPLE:
            begin
            end
            K_DIV:
            begin
                // all ones is past any bound, so an early overflow clamps
                re_sat = sat_put(up_data.side.neg_re,
                                 up_data.ovf_re ? {MW{1'b1}} : MW'(up_data.q_re));
                im_sat = sat_put(up_data.side.neg_im,
                                 up_data.ovf_im ? {MW{1'b1}} : MW'(up_data.q_im));
                out_next.res_re = re_sat.val;
                out_next.res_im = im_sat.val;
                out_next.status = (re_sat.ovf || im_sat.ovf) ? ST_SAT : ST_OK;
            end
            K_MOD:
            begin
                re_sat = sat_put(1'b0, MW'(up_data.root));
                out_next.res_re = re_sat.val;
                out_next.res_im = '0;
                out_next.status = re_sat.ovf ? ST_SAT : ST_OK;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            out_valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            out_reg <= out_next;
        end
    end

endmodule

[rtl/complex_arithmetic_unit.sv]
// throughput: one word per cycle; every stage holds its own valid bit and
// bubbles close up, so a stall at the output only backs up full stages
// depth is set by the shared quotient and square root stages, one bit each
// reset: rst_n asynchronous, clears all valid bits; the datapath registers are not reset
module complex_arithmetic_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  cau_pkg::in_word_t  req_word,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output cau_pkg::out_word_t rsp_word
);
    import cau_pkg::*;

    // front to iterative section
    logic      fr_valid;
    logic      fr_ready;
    front_t    fr_data;

    // iterative section to output stage
    logic      it_valid;
    logic      it_ready;
    iter_out_t it_data;

    logic      front_ready;

    // an input word is taken whenever the first stage can move
    assign req_stall = !front_ready;

    // three stages: products, cross sums, magnitudes plus the
    // add, add-integer, conjugate and multiply results
    cau_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (req_valid),
        .up_ready (front_ready),
        .up_data  (req_word),
        .dn_valid (fr_valid),
        .dn_ready (fr_ready),
        .dn_data  (fr_data)
    );

    // DATA_WIDTH stages: restoring divide for both parts of a/b and the
    // integer square root for the modulus run side by side
    cau_iter u_iter (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (fr_valid),
        .up_ready (fr_ready),
        .up_data  (fr_data),
        .dn_valid (it_valid),
        .dn_ready (it_ready),
        .dn_data  (it_data)
    );

    // sign, saturation and the registered result word
    cau_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (it_valid),
        .up_ready (it_ready),
        .up_data  (it_data),
        .dn_valid (rsp_valid),
        .dn_stall (rsp_stall),
        .dn_data  (rsp_word)
    );

endmodule

[rtl/cau_checker.sv]
// port-level checks of the complex arithmetic unit and their binding
`include "assert_macros.svh"

module cau_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input cau_pkg::in_word_t  req_word,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input cau_pkg::out_word_t rsp_word
);
    import cau_pkg::*;

    localparam data_t D_MAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    localparam data_t D_MIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

    logic  sat_re;
    logic  sat_im;
    logic  req_seen;

    assign sat_re   = (rsp_word.res_re == D_MAX) || (rsp_word.res_re == D_MIN);
    assign sat_im   = (rsp_word.res_im == D_MAX) || (rsp_word.res_im == D_MIN);
    assign req_seen = req_valid && (req_word.func == req_word.func);

    // a waiting result word holds
    `CHK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))

    // with the output free the whole pipeline moves, so no input stall
    `CHK_HOLDS(a_free_flow, req_seen && (!rsp_valid || !rsp_stall), !req_stall)

    // divide by zero gives a zero result
    `CHK_HOLDS(a_div0_zero, rsp_valid && (rsp_word.status == ST_DIV0), (rsp_word.res_re == '0) && (rsp_word.res_im == '0))

    // a saturated result sits on a bound in at least one part
    `CHK_HOLDS(a_sat_bound, rsp_valid && (rsp_word.status == ST_SAT), sat_re || sat_im)

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);
